[hw/rtl/bounded_deque_with_search_assert.svh]
// Assertion macros shared by the deque RTL.
// Both macros sample on the rising edge of i_clk and are idle while reset is held.
`ifndef BOUNDED_DEQUE_WITH_SEARCH_ASSERT_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_ASSERT_SVH

// Same-cycle implication.
`define BDQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/bdq_pkg.sv]
`default_nettype none

package bdq_pkg;

    // Capacity of the ring and the widths that follow from it.
    localparam int DEPTH       = 64;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int DATA_W      = 32;
    localparam int REQ_W       = 3;
    localparam int COUNT_OUT_W = 7;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_POP_FRONT  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_POP_BACK   = 3'd3;
    localparam logic [REQ_W-1:0] REQ_SEARCH     = 3'd4;

    // Value reported for an empty pop and for the ends of an empty queue.
    localparam logic signed [DATA_W-1:0] EMPTY_MARK = '1;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [CNT_W-1:0]  t_count;

    // Ring position at a given offset from the base; base is below DEPTH and the
    // offset at most DEPTH, so one compare and subtract wraps the sum.
    function automatic t_addr ring_at(input t_addr base, input t_count off);
        logic [ADDR_W:0] sum;
        sum = {1'b0, base} + (ADDR_W + 1)'(off);
        if (sum >= (ADDR_W + 1)'(DEPTH)) begin
            sum = sum - (ADDR_W + 1)'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

    // Ring position one step before the base.
    function automatic t_addr ring_dec(input t_addr base);
        t_addr res;
        if (base == '0) begin
            res = ADDR_W'(DEPTH - 1);
        end else begin
            res = base - ADDR_W'(1);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/bdq_ram.sv]
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write, then read; the read data is registered.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

[hw/rtl/bounded_deque_with_search.sv]
// Double-ended queue of signed 32-bit values with a linear search.
// Input channel: i_valid / o_ready carry i_req_type and i_operand_value; an
// item is taken at a rising edge where both are high. Output channel: o_valid
// and i_ready carry one result item per request, with the entry count and the
// front and back values after the request (-1 for both ends when it is empty).
// One item is worked on at a time; o_ready is high only while the block is
// idle, so it drops after each acceptance.
// Steps from the accepting edge to the load of the output register: a push,
// an empty pop, a search of an empty queue or an unused code goes straight to
// the final step; a pop that leaves entries behind first passes the pop step,
// as the new end is read back from the entry RAM; a search walks the entries
// until it finds the value or passes the last one, reading one entry per cycle
// through the single RAM read port. A new item is taken only once the result
// of the last one has been loaded into the output register.
// The output register holds a result until it is taken, and the next item may
// be accepted meanwhile; that item waits in its final step, with o_ready low,
// while the receiver stalls. Reset empties the queue (front pointer and count
// cleared) and drops any pending result; the entry RAM is not cleared, as only
// entries written by a push are ever used.
`default_nettype none

`include "bounded_deque_with_search_assert.svh"

module bounded_deque_with_search (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic [bdq_pkg::REQ_W-1:0]           i_req_type,
    input  wire logic signed [bdq_pkg::DATA_W-1:0]   i_operand_value,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic signed [bdq_pkg::DATA_W-1:0]        o_result_value,
    output logic                                     o_underflow_error,
    output logic                                     o_overflow_error,
    output logic [bdq_pkg::COUNT_OUT_W-1:0]          o_entry_count,
    output logic signed [bdq_pkg::DATA_W-1:0]        o_front_entry,
    output logic signed [bdq_pkg::DATA_W-1:0]        o_back_entry
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_POP,
        S_SEARCH,
        S_DONE
    } t_state;

    t_state                              r_state;
    bdq_pkg::t_addr                      r_front;
    bdq_pkg::t_count                     r_count;
    logic signed [bdq_pkg::DATA_W-1:0]   r_front_val;
    logic signed [bdq_pkg::DATA_W-1:0]   r_back_val;
    logic signed [bdq_pkg::DATA_W-1:0]   r_res;
    logic                                r_under;
    logic                                r_over;
    logic                                r_pop_front;
    logic signed [bdq_pkg::DATA_W-1:0]   r_key;
    bdq_pkg::t_addr                      r_cmp;

    logic                                r_out_valid;
    logic signed [bdq_pkg::DATA_W-1:0]   r_out_res;
    logic                                r_out_under;
    logic                                r_out_over;
    logic [bdq_pkg::COUNT_OUT_W-1:0]     r_out_count;
    logic signed [bdq_pkg::DATA_W-1:0]   r_out_front;
    logic signed [bdq_pkg::DATA_W-1:0]   r_out_back;

    logic                                accept;
    logic                                is_full;
    logic                                is_empty;
    logic                                is_push;
    bdq_pkg::t_addr                      front_dec;
    bdq_pkg::t_addr                      back_slot;
    logic                                ram_wr_en;
    bdq_pkg::t_addr                      ram_wr_addr;
    bdq_pkg::t_addr                      ram_rd_addr;
    logic [bdq_pkg::DATA_W-1:0]          ram_rd_data;

    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign is_full  = (r_count == bdq_pkg::CNT_W'(bdq_pkg::DEPTH));
    assign is_empty = (r_count == '0);
    assign is_push  = (i_req_type == bdq_pkg::REQ_PUSH_FRONT)
                   || (i_req_type == bdq_pkg::REQ_PUSH_BACK);

    // Ring slots in front of the front entry and behind the back entry.
    assign front_dec = bdq_pkg::ring_dec(r_front);
    assign back_slot = bdq_pkg::ring_at(r_front, r_count);

    // A push writes its value straight into the ring.
    assign ram_wr_en   = accept && is_push && !is_full;
    assign ram_wr_addr = (i_req_type == bdq_pkg::REQ_PUSH_FRONT) ? front_dec : back_slot;

    // Read the entry that becomes the new end after a pop, or the next entry
    // of a search walk.
    always_comb begin
        ram_rd_addr = r_front;
        if (r_state == S_IDLE) begin
            if (i_req_type == bdq_pkg::REQ_POP_FRONT) begin
                ram_rd_addr = bdq_pkg::ring_at(r_front, bdq_pkg::CNT_W'(1));
            end else if (i_req_type == bdq_pkg::REQ_POP_BACK) begin
                ram_rd_addr = bdq_pkg::ring_at(r_front, r_count - bdq_pkg::CNT_W'(2));
            end
        end else if (r_state == S_SEARCH) begin
            ram_rd_addr = bdq_pkg::ring_at(r_front,
                bdq_pkg::CNT_W'(r_cmp) + bdq_pkg::CNT_W'(1));
        end
    end

    bdq_ram #(
        .WIDTH (bdq_pkg::DATA_W),
        .DEPTH (bdq_pkg::DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (i_operand_value),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    // Request sequencer, cached end values and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // A taken result frees the register unless a new one is loaded now.
            if (r_out_valid && i_ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        unique case (i_req_type)
                            bdq_pkg::REQ_PUSH_FRONT: begin
                                r_res   <= '0;
                                r_under <= 1'b0;
                                r_over  <= is_full;
                                r_state <= S_DONE;
                                if (!is_full) begin
                                    r_front     <= front_dec;
                                    r_count     <= r_count + bdq_pkg::CNT_W'(1);
                                    r_front_val <= i_operand_value;
                                    if (is_empty) begin
                                        r_back_val <= i_operand_value;
                                    end
                                end
                            end
                            bdq_pkg::REQ_PUSH_BACK: begin
                                r_res   <= '0;
                                r_under <= 1'b0;
                                r_over  <= is_full;
                                r_state <= S_DONE;
                                if (!is_full) begin
                                    r_count    <= r_count + bdq_pkg::CNT_W'(1);
                                    r_back_val <= i_operand_value;
                                    if (is_empty) begin
                                        r_front_val <= i_operand_value;
                                    end
                                end
                            end
                            bdq_pkg::REQ_POP_FRONT: begin
                                r_over <= 1'b0;
                                if (is_empty) begin
                                    r_res   <= bdq_pkg::EMPTY_MARK;
                                    r_under <= 1'b1;
                                    r_state <= S_DONE;
                                end else begin
                                    r_res       <= r_front_val;
                                    r_under     <= 1'b0;
                                    r_front     <= bdq_pkg::ring_at(r_front,
                                                       bdq_pkg::CNT_W'(1));
                                    r_count     <= r_count - bdq_pkg::CNT_W'(1);
                                    r_pop_front <= 1'b1;
                                    if (r_count != bdq_pkg::CNT_W'(1)) begin
                                        r_state <= S_POP;
                                    end else begin
                                        r_state <= S_DONE;
                                    end
                                end
                            end
                            bdq_pkg::REQ_POP_BACK: begin
                                r_over <= 1'b0;
                                if (is_empty) begin
                                    r_res   <= bdq_pkg::EMPTY_MARK;
                                    r_under <= 1'b1;
                                    r_state <= S_DONE;
                                end else begin
                                    r_res       <= r_back_val;
                                    r_under     <= 1'b0;
                                    r_count     <= r_count - bdq_pkg::CNT_W'(1);
                                    r_pop_front <= 1'b0;
                                    if (r_count != bdq_pkg::CNT_W'(1)) begin
                                        r_state <= S_POP;
                                    end else begin
                                        r_state <= S_DONE;
                                    end
                                end
                            end
                            bdq_pkg::REQ_SEARCH: begin
                                r_res   <= '0;
                                r_under <= 1'b0;
                                r_over  <= 1'b0;
                                r_key   <= i_operand_value;
                                r_cmp   <= '0;
                                if (is_empty) begin
                                    r_state <= S_DONE;
                                end else begin
                                    r_state <= S_SEARCH;
                                end
                            end
                            default: begin
                                r_res   <= '0;
                                r_under <= 1'b0;
                                r_over  <= 1'b0;
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_POP: begin
                    // The new end entry arrives from the RAM.
                    if (r_pop_front) begin
                        r_front_val <= ram_rd_data;
                    end else begin
                        r_back_val <= ram_rd_data;
                    end
                    r_state <= S_DONE;
                end
                S_SEARCH: begin
                    // Compare one entry per cycle, the next read already issued.
                    if (ram_rd_data == r_key) begin
                        r_res   <= bdq_pkg::DATA_W'(r_cmp);
                        r_state <= S_DONE;
                    end else if (bdq_pkg::CNT_W'(r_cmp)
                                 == r_count - bdq_pkg::CNT_W'(1)) begin
                        r_res   <= bdq_pkg::DATA_W'(r_count);
                        r_state <= S_DONE;
                    end else begin
                        r_cmp <= r_cmp + bdq_pkg::ADDR_W'(1);
                    end
                end
                S_DONE: begin
                    // Load the result once the output register is free.
                    if (!r_out_valid || i_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_res   <= r_res;
                        r_out_under <= r_under;
                        r_out_over  <= r_over;
                        r_out_count <= bdq_pkg::COUNT_OUT_W'(r_count);
                        r_out_front <= is_empty ? bdq_pkg::EMPTY_MARK : r_front_val;
                        r_out_back  <= is_empty ? bdq_pkg::EMPTY_MARK : r_back_val;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid           = r_out_valid;
    assign o_result_value    = r_out_res;
    assign o_underflow_error = r_out_under;
    assign o_overflow_error  = r_out_over;
    assign o_entry_count     = r_out_count;
    assign o_front_entry     = r_out_front;
    assign o_back_entry      = r_out_back;

    // A push into a queue with room grows it by exactly one entry.
    `BDQ_ASSERT_NEXT(a_push_grows, accept && is_push && !is_full,
        r_count == $past(r_count) + bdq_pkg::CNT_W'(1), "push did not grow the queue by one")

    // The search walk never compares beyond the stored entries.
    `BDQ_ASSERT_NOW(a_search_in_range, r_state == S_SEARCH,
        bdq_pkg::CNT_W'(r_cmp) < r_count, "search index beyond the entry count")

    // An empty queue reports both ends as the empty mark.
    `BDQ_ASSERT_NOW(a_empty_ends, o_valid && o_entry_count == '0,
        o_front_entry == bdq_pkg::EMPTY_MARK && o_back_entry == bdq_pkg::EMPTY_MARK,
        "empty queue reported with a stored end value")

endmodule

`default_nettype wire
